/* sv/fhtc_pkg.sv */
`timescale 1ns / 1ps

package fhtc_pkg;

    // Field widths of the item channels
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 32;
    localparam int CMD_W    = 2;
    localparam int RANK_W   = 4;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] STS_TOO_SMALL = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [RANK_W-1:0] rank;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   result_address;
        logic [LEN_W-1:0]    result_length;
        logic [TOTAL_W-1:0]  hole_total;
    } rsp_item_t;

    // Sequencer steps
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_REMOVE,
        ST_INS_EVAL,
        ST_INS_COMMIT,
        ST_UNDO,
        ST_READ
    } state_t;

    // Action broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_INSERT,
        CELL_MERGE_PREV,
        CELL_MERGE_NEXT,
        CELL_MERGE_BOTH
    } cell_op_t;

    // Per-cell match results, reduced at the top
    typedef struct packed {
        logic hit;
        logic small_hole;
        logic eq;
        logic mp;
        logic ms;
        logic ovf_prev;
        logic ovf_next;
        logic ovf_both;
    } cell_flags_t;

endpackage

/* sv/free_hole_table_coalescing_top.sv */
`timescale 1ns / 1ps

// Free-hole table with coalescing. Holes (start, size) are kept sorted by start in a row of
// MAX_HOLES cells; every cell compares its hole against a broadcast key and moves data to or
// from its neighbors, and a small sequencer walks an item through these row steps. After
// acceptance, a read runs READ; a query and a failed allocate run FIND; a free runs INS_EVAL
// then INS_COMMIT, ending in INS_EVAL when it is out of range, zero-length, lands on an
// existing start or finds the table full or the merged size too wide. An allocate runs FIND
// and REMOVE, ending there when it exactly empties its hole, then INS_EVAL, ending there when
// the remainder lands on an existing start, then INS_COMMIT to put the remainder back, or
// UNDO to restore the hole when the put-back fails. Each is a compare-and-move step across
// the cell row; the next item is taken in the cycle the last step completes. One result
// item comes out per request item, through an output register, so a waiting result still lets
// the next request in, which then holds in its last step until the waiting result is taken.
// Configuration (region_base) is written on the cfg channel, which is always ready.
module free_hole_table_coalescing_top #(
    parameter int MAX_HOLES = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  fhtc_pkg::req_item_t           req_item,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output fhtc_pkg::rsp_item_t           rsp_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fhtc_pkg::ADDR_W-1:0]   cfg_data
);

    localparam int ADDR_W     = fhtc_pkg::ADDR_W;
    localparam int LEN_W      = fhtc_pkg::LEN_W;
    localparam int RANK_W     = fhtc_pkg::RANK_W;
    localparam int TOTAL_W    = fhtc_pkg::TOTAL_W;
    localparam int START_W    = (ADDR_BITS > ADDR_W) ? ADDR_W + 1 : ADDR_W;
    localparam int END_W      = START_W + 1;
    localparam int CNT_W      = $clog2(MAX_HOLES + 1);
    localparam int RANK_CELLS = (MAX_HOLES < (1 << RANK_W)) ? MAX_HOLES : (1 << RANK_W);
    localparam logic [65:0] ADDR_SPAN = 66'(1) << ADDR_BITS;

    // Sequencer and item registers
    fhtc_pkg::state_t          state_reg, state_next;
    logic [fhtc_pkg::CMD_W-1:0] cmd_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [RANK_W-1:0]         rank_reg;
    logic                      pre_bad_reg;
    logic [START_W-1:0]        key_s_reg;
    logic [LEN_W-1:0]          key_l_reg;
    logic [END_W-1:0]          key_e_reg;
    logic [LEN_W-1:0]          hit_size_reg;
    logic                      mp_reg;
    logic                      ms_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [ADDR_W-1:0]         base_reg;
    logic                      rsp_valid_reg;
    fhtc_pkg::rsp_item_t       rsp_item_reg;

    // Cell row
    logic                      cell_valid [MAX_HOLES];
    logic [START_W-1:0]        cell_start [MAX_HOLES];
    logic [LEN_W-1:0]          cell_size  [MAX_HOLES];
    logic [END_W-1:0]          cell_end   [MAX_HOLES];
    logic                      cell_lt    [MAX_HOLES];
    fhtc_pkg::cell_flags_t     cell_flags [MAX_HOLES];
    fhtc_pkg::cell_op_t        cell_op, op_raw;

    // Reductions over the row
    logic                      any_hit, any_small, any_eq, any_mp, any_ms;
    logic                      any_ovf_prev, any_ovf_next, any_ovf_both;
    logic [LEN_W-1:0]          gather_size;

    // Step control
    logic                      fin;
    fhtc_pkg::state_t          cont_state;
    logic                      out_free;
    logic                      hold;
    logic                      accept;
    logic [CNT_W-1:0]          count_new;
    logic [fhtc_pkg::STATUS_W-1:0] res_status;
    logic [ADDR_W-1:0]         res_ra;
    logic [LEN_W-1:0]          res_rl;
    logic [CNT_W+TOTAL_W-1:0]  cnt_ext;

    // Item arithmetic
    logic [ADDR_W:0]           sum_al;
    logic [LEN_W-1:0]          rest;
    logic                      is_free;
    logic                      is_alloc;
    logic [ADDR_W-1:0]         alloc_ra;
    logic                      full;
    logic                      ovf_sel;
    logic                      ins_fail;
    logic [65:0]               req_sum;
    logic                      req_bad;
    logic                      rank_bad;
    logic [START_W-1:0]        sel_start;
    logic [LEN_W-1:0]          sel_size;

    function automatic fhtc_pkg::state_t entry_state(input logic [fhtc_pkg::CMD_W-1:0] c);
        fhtc_pkg::state_t s;
        case (c)
            fhtc_pkg::CMD_FREE:  s = fhtc_pkg::ST_INS_EVAL;
            fhtc_pkg::CMD_ALLOC: s = fhtc_pkg::ST_FIND;
            fhtc_pkg::CMD_QUERY: s = fhtc_pkg::ST_FIND;
            fhtc_pkg::CMD_READ:  s = fhtc_pkg::ST_READ;
            default:             s = fhtc_pkg::ST_READ;
        endcase
        return s;
    endfunction

    // Build the row; edge cells see an empty neighbor
    for (genvar i = 0; i < MAX_HOLES; i++)
    begin : g_cell
        logic               l_valid, l_lt, r_valid, r_lt;
        logic [START_W-1:0] l_start, r_start;
        logic [LEN_W-1:0]   l_size, r_size;
        logic [END_W-1:0]   l_end, r_end;

        if (i == 0)
        begin : g_left_edge
            assign l_valid = 1'b0;
            assign l_start = '0;
            assign l_size  = '0;
            assign l_end   = '0;
            assign l_lt    = 1'b1;
        end
        else
        begin : g_left
            assign l_valid = cell_valid[i-1];
            assign l_start = cell_start[i-1];
            assign l_size  = cell_size[i-1];
            assign l_end   = cell_end[i-1];
            assign l_lt    = cell_lt[i-1];
        end

        if (i == MAX_HOLES - 1)
        begin : g_right_edge
            assign r_valid = 1'b0;
            assign r_start = '0;
            assign r_size  = '0;
            assign r_end   = '0;
            assign r_lt    = 1'b0;
        end
        else
        begin : g_right
            assign r_valid = cell_valid[i+1];
            assign r_start = cell_start[i+1];
            assign r_size  = cell_size[i+1];
            assign r_end   = cell_end[i+1];
            assign r_lt    = cell_lt[i+1];
        end

        fhtc_cell #(
            .START_W (START_W),
            .END_W   (END_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (cell_op),
            .key_s       (key_s_reg),
            .key_l       (key_l_reg),
            .key_e       (key_e_reg),
            .left_valid  (l_valid),
            .left_start  (l_start),
            .left_size   (l_size),
            .left_end    (l_end),
            .left_lt     (l_lt),
            .right_valid (r_valid),
            .right_start (r_start),
            .right_size  (r_size),
            .right_end   (r_end),
            .right_lt    (r_lt),
            .valid       (cell_valid[i]),
            .start       (cell_start[i]),
            .size        (cell_size[i]),
            .hole_end    (cell_end[i]),
            .lt          (cell_lt[i]),
            .flags       (cell_flags[i])
        );
    end

    // Reduce cell flags and gather the size of the matching hole
    always_comb
    begin
        any_hit      = 1'b0;
        any_small    = 1'b0;
        any_eq       = 1'b0;
        any_mp       = 1'b0;
        any_ms       = 1'b0;
        any_ovf_prev = 1'b0;
        any_ovf_next = 1'b0;
        any_ovf_both = 1'b0;
        gather_size  = '0;
        for (int i = 0; i < MAX_HOLES; i++)
        begin
            any_hit      = any_hit | cell_flags[i].hit;
            any_small    = any_small | cell_flags[i].small_hole;
            any_eq       = any_eq | cell_flags[i].eq;
            any_mp       = any_mp | cell_flags[i].mp;
            any_ms       = any_ms | cell_flags[i].ms;
            any_ovf_prev = any_ovf_prev | cell_flags[i].ovf_prev;
            any_ovf_next = any_ovf_next | cell_flags[i].ovf_next;
            any_ovf_both = any_ovf_both | cell_flags[i].ovf_both;
            if (cell_flags[i].hit)
            begin
                gather_size = gather_size | cell_size[i];
            end
        end
    end

    // Select the hole at the requested rank
    always_comb
    begin
        sel_start = '0;
        sel_size  = '0;
        for (int j = 0; j < RANK_CELLS; j++)
        begin
            if (rank_reg == RANK_W'(j))
            begin
                sel_start = cell_start[j];
                sel_size  = cell_size[j];
            end
        end
    end

    // Item arithmetic and merge decision
    assign sum_al   = {1'b0, addr_reg} + {1'b0, len_reg};
    assign rest     = hit_size_reg - len_reg;
    assign is_free  = (cmd_reg == fhtc_pkg::CMD_FREE);
    assign is_alloc = (cmd_reg == fhtc_pkg::CMD_ALLOC);
    assign alloc_ra = is_alloc ? sum_al[ADDR_W-1:0] : '0;
    assign full     = (count_reg == CNT_W'(MAX_HOLES));
    assign ovf_sel  = (any_mp && any_ms) ? any_ovf_both :
                      any_mp ? any_ovf_prev :
                      any_ms ? any_ovf_next : 1'b0;
    assign ins_fail = ovf_sel || (!any_mp && !any_ms && full);
    assign rank_bad = ((CNT_W + RANK_W)'(rank_reg) >= (CNT_W + RANK_W)'(count_reg));

    // Range check of a freed hole against the address space
    assign req_sum = 66'(req_item.address) + 66'(req_item.length);
    assign req_bad = (66'(req_item.address) >= ADDR_SPAN) ||
                     ((req_item.length != '0) && (req_sum > ADDR_SPAN));

    // Handshake
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign hold      = fin && !out_free;
    assign req_stall = !((state_reg == fhtc_pkg::ST_IDLE) || (fin && out_free));
    assign accept    = req_valid && !req_stall;
    assign cell_op   = hold ? fhtc_pkg::CELL_HOLD : op_raw;
    assign count_next = hold ? count_reg : count_new;

    // Sequencer outputs: row action, completion and result of the current step
    always_comb
    begin
        fin        = 1'b0;
        cont_state = state_reg;
        op_raw     = fhtc_pkg::CELL_HOLD;
        res_status = fhtc_pkg::STS_OK;
        res_ra     = '0;
        res_rl     = '0;
        count_new  = count_reg;
        case (state_reg)
            fhtc_pkg::ST_FIND:
            begin
                if (!any_hit)
                begin
                    fin        = 1'b1;
                    res_status = fhtc_pkg::STS_NOT_FOUND;
                end
                else if (cmd_reg == fhtc_pkg::CMD_QUERY)
                begin
                    fin    = 1'b1;
                    res_rl = gather_size;
                end
                else if (any_small)
                begin
                    fin        = 1'b1;
                    res_status = fhtc_pkg::STS_TOO_SMALL;
                end
                else
                begin
                    cont_state = fhtc_pkg::ST_REMOVE;
                end
            end
            fhtc_pkg::ST_REMOVE:
            begin
                op_raw    = fhtc_pkg::CELL_REMOVE;
                count_new = count_reg - CNT_W'(1);
                if (rest == '0)
                begin
                    fin    = 1'b1;
                    res_ra = sum_al[ADDR_W-1:0];
                end
                else
                begin
                    cont_state = fhtc_pkg::ST_INS_EVAL;
                end
            end
            fhtc_pkg::ST_INS_EVAL:
            begin
                if (is_free && pre_bad_reg)
                begin
                    fin        = 1'b1;
                    res_status = fhtc_pkg::STS_FULL;
                end
                else if (is_free && (len_reg == '0))
                begin
                    fin = 1'b1;
                end
                else if (any_eq)
                begin
                    fin    = 1'b1;
                    res_ra = alloc_ra;
                end
                else if (ins_fail)
                begin
                    if (is_alloc)
                    begin
                        cont_state = fhtc_pkg::ST_UNDO;
                    end
                    else
                    begin
                        fin        = 1'b1;
                        res_status = fhtc_pkg::STS_FULL;
                    end
                end
                else
                begin
                    cont_state = fhtc_pkg::ST_INS_COMMIT;
                end
            end
            fhtc_pkg::ST_INS_COMMIT:
            begin
                fin    = 1'b1;
                res_ra = alloc_ra;
                if (mp_reg && ms_reg)
                begin
                    op_raw    = fhtc_pkg::CELL_MERGE_BOTH;
                    count_new = count_reg - CNT_W'(1);
                end
                else if (mp_reg)
                begin
                    op_raw = fhtc_pkg::CELL_MERGE_PREV;
                end
                else if (ms_reg)
                begin
                    op_raw = fhtc_pkg::CELL_MERGE_NEXT;
                end
                else
                begin
                    op_raw    = fhtc_pkg::CELL_INSERT;
                    count_new = count_reg + CNT_W'(1);
                end
            end
            fhtc_pkg::ST_UNDO:
            begin
                fin        = 1'b1;
                res_status = fhtc_pkg::STS_FULL;
                op_raw     = fhtc_pkg::CELL_INSERT;
                count_new  = count_reg + CNT_W'(1);
            end
            fhtc_pkg::ST_READ:
            begin
                fin = 1'b1;
                if (rank_bad)
                begin
                    res_status = fhtc_pkg::STS_RANGE;
                end
                else
                begin
                    res_ra = sel_start[ADDR_W-1:0] - base_reg;
                    res_rl = sel_size;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        if (state_reg == fhtc_pkg::ST_IDLE)
        begin
            if (accept)
            begin
                state_next = entry_state(req_item.command);
            end
        end
        else if (hold)
        begin
            state_next = state_reg;
        end
        else if (fin)
        begin
            state_next = accept ? entry_state(req_item.command) : fhtc_pkg::ST_IDLE;
        end
        else
        begin
            state_next = cont_state;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fhtc_pkg::ST_IDLE;
            count_reg     <= '0;
            base_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
            if (fin && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result item
    assign cnt_ext = (CNT_W + TOTAL_W)'(count_next);

    always_ff @(posedge clk)
    begin
        if (fin && out_free)
        begin
            rsp_item_reg.status         <= res_status;
            rsp_item_reg.result_address <= res_ra;
            rsp_item_reg.result_length  <= res_rl;
            rsp_item_reg.hole_total     <= cnt_ext[TOTAL_W-1:0];
        end
    end

    // Take a new item, or advance the keys for the next row step
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= req_item.command;
            addr_reg    <= req_item.address;
            len_reg     <= req_item.length;
            rank_reg    <= req_item.rank;
            pre_bad_reg <= req_bad;
            key_s_reg   <= START_W'(req_item.address);
            key_l_reg   <= req_item.length;
            key_e_reg   <= END_W'(req_sum[ADDR_W:0]);
        end
        else if (!hold)
        begin
            case (state_reg)
                fhtc_pkg::ST_FIND:
                begin
                    hit_size_reg <= gather_size;
                end
                fhtc_pkg::ST_REMOVE:
                begin
                    key_s_reg <= START_W'(sum_al);
                    key_l_reg <= rest;
                    key_e_reg <= END_W'(addr_reg) + END_W'(hit_size_reg);
                end
                fhtc_pkg::ST_INS_EVAL:
                begin
                    mp_reg <= any_mp;
                    ms_reg <= any_ms;
                    if (ins_fail && is_alloc)
                    begin
                        key_s_reg <= START_W'(addr_reg);
                        key_l_reg <= hit_size_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;
    assign cfg_ready = 1'b1;

endmodule

/* sv/fhtc_cell.sv */
`timescale 1ns / 1ps

module fhtc_cell #(
    parameter int START_W = 32,
    parameter int END_W   = 33
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fhtc_pkg::cell_op_t          op,
    input  logic [START_W-1:0]          key_s,
    input  logic [fhtc_pkg::LEN_W-1:0]  key_l,
    input  logic [END_W-1:0]            key_e,
    input  logic                        left_valid,
    input  logic [START_W-1:0]          left_start,
    input  logic [fhtc_pkg::LEN_W-1:0]  left_size,
    input  logic [END_W-1:0]            left_end,
    input  logic                        left_lt,
    input  logic                        right_valid,
    input  logic [START_W-1:0]          right_start,
    input  logic [fhtc_pkg::LEN_W-1:0]  right_size,
    input  logic [END_W-1:0]            right_end,
    input  logic                        right_lt,
    output logic                        valid,
    output logic [START_W-1:0]          start,
    output logic [fhtc_pkg::LEN_W-1:0]  size,
    output logic [END_W-1:0]            hole_end,
    output logic                        lt,
    output fhtc_pkg::cell_flags_t       flags
);

    localparam int LEN_W = fhtc_pkg::LEN_W;

    logic                valid_reg, valid_next;
    logic [START_W-1:0]  start_reg, start_next;
    logic [LEN_W-1:0]    size_reg, size_next;
    logic [END_W-1:0]    end_reg, end_next;

    logic                pos;
    logic                pred;
    logic                succ;
    logic [END_W-1:0]    diff_prev;
    logic [END_W-1:0]    diff_next;
    logic [END_W-1:0]    diff_both;

    // Locate this cell relative to the key: below it, the insert point, or the one just below
    assign lt   = valid_reg && (start_reg < key_s);
    assign pos  = !lt && left_lt;
    assign pred = lt && !right_lt;
    assign succ = pos && valid_reg;

    // Merged sizes for each way this cell can join the new hole
    assign diff_prev = key_e - END_W'(start_reg);
    assign diff_next = end_reg - END_W'(key_s);
    assign diff_both = right_end - END_W'(start_reg);

    // Report matches and merge overflows
    always_comb
    begin
        flags.hit        = valid_reg && (start_reg == key_s);
        flags.small_hole = flags.hit && (size_reg < key_l);
        flags.eq         = succ && (start_reg == key_s);
        flags.mp         = pred && (end_reg == END_W'(key_s));
        flags.ms         = succ && (END_W'(start_reg) == key_e);
        flags.ovf_prev   = pred && (|diff_prev[END_W-1:LEN_W]);
        flags.ovf_next   = succ && (|diff_next[END_W-1:LEN_W]);
        flags.ovf_both   = pred && (|diff_both[END_W-1:LEN_W]);
    end

    // Pick the next contents: hold, take a neighbor, load the key, or merge
    always_comb
    begin
        valid_next = valid_reg;
        start_next = start_reg;
        size_next  = size_reg;
        end_next   = end_reg;
        case (op)
            fhtc_pkg::CELL_REMOVE:
            begin
                if (!lt)
                begin
                    valid_next = right_valid;
                    start_next = right_start;
                    size_next  = right_size;
                    end_next   = right_end;
                end
            end
            fhtc_pkg::CELL_INSERT:
            begin
                if (pos)
                begin
                    valid_next = 1'b1;
                    start_next = key_s;
                    size_next  = key_l;
                    end_next   = key_e;
                end
                else if (!lt)
                begin
                    valid_next = left_valid;
                    start_next = left_start;
                    size_next  = left_size;
                    end_next   = left_end;
                end
            end
            fhtc_pkg::CELL_MERGE_PREV:
            begin
                if (pred)
                begin
                    size_next = diff_prev[LEN_W-1:0];
                    end_next  = key_e;
                end
            end
            fhtc_pkg::CELL_MERGE_NEXT:
            begin
                if (succ)
                begin
                    start_next = key_s;
                    size_next  = diff_next[LEN_W-1:0];
                end
            end
            fhtc_pkg::CELL_MERGE_BOTH:
            begin
                if (pred)
                begin
                    size_next = diff_both[LEN_W-1:0];
                    end_next  = right_end;
                end
                else if (!lt)
                begin
                    valid_next = right_valid;
                    start_next = right_start;
                    size_next  = right_size;
                    end_next   = right_end;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hole contents
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        size_reg  <= size_next;
        end_reg   <= end_next;
    end

    assign valid    = valid_reg;
    assign start    = start_reg;
    assign size     = size_reg;
    assign hole_end = end_reg;

endmodule

/* test/free_hole_table_coalescing_top_test.sv */
`timescale 1ns / 1ps

module free_hole_table_coalescing_top_test;

    localparam int MAX_HOLES = 16;
    localparam int CMD_W = fhtc_pkg::CMD_W;
    localparam int RANK_W = fhtc_pkg::RANK_W;
    localparam int STATUS_W = fhtc_pkg::STATUS_W;
    localparam int TOTAL_W = fhtc_pkg::TOTAL_W;
    localparam bit [63:0] SPACE_TOP = 64'hFFFF_FFFF;
    localparam int WAIT_LIMIT = 5000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 292;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } stall_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    fhtc_pkg::req_item_t   req_item = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    fhtc_pkg::rsp_item_t   rsp_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [31:0]           cfg_data = '0;

    // Hole table as the block should hold it
    bit [63:0] tbl_start [MAX_HOLES];
    bit [63:0] tbl_size [MAX_HOLES];
    int        tbl_count = 0;
    bit [63:0] base_reg = 0;

    fhtc_pkg::req_item_t req_backlog [$];
    fhtc_pkg::rsp_item_t pending_rsp [$];
    int        fail_count = 0;

    // Sender burst state
    int burst_left = 1;
    int gap_left = 0;

    // Receiver stall state
    int          hold_trigger = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          seg_left = 0;
    stall_mode_t seg_mode = STALL_NONE;

    fhtc_pkg::rsp_item_t want_rsp;

    free_hole_table_coalescing_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        fail_count++;
        $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $time);
    endtask

    function automatic int table_find(bit [63:0] s);
        int i;
        for (i = 0; i < tbl_count; i++)
            if (tbl_start[i] == s)
                return i;
        return -1;
    endfunction

    function automatic void table_remove(int p);
        int i;
        for (i = p; i + 1 < tbl_count; i++)
        begin
            tbl_start[i] = tbl_start[i + 1];
            tbl_size[i] = tbl_size[i + 1];
        end
        tbl_count--;
    endfunction

    // Insert a hole and merge it with touching neighbors; no change on error
    function automatic logic [STATUS_W-1:0] table_insert(bit [63:0] s, bit [63:0] l);
        int p;
        int i;
        bit mp;
        bit ms;
        bit [63:0] ns;
        bit [63:0] ne;
        p = 0;
        while (p < tbl_count && tbl_start[p] < s)
            p++;
        if (p < tbl_count && tbl_start[p] == s)
            return fhtc_pkg::STS_OK;
        mp = 1'b0;
        ms = 1'b0;
        if (p > 0)
            mp = (tbl_start[p - 1] + tbl_size[p - 1] == s);
        if (p < tbl_count)
            ms = (s + l == tbl_start[p]);
        ns = mp ? tbl_start[p - 1] : s;
        ne = ms ? tbl_start[p] + tbl_size[p] : s + l;
        if (ne - ns > SPACE_TOP)
            return fhtc_pkg::STS_FULL;
        if (!mp && !ms && tbl_count >= MAX_HOLES)
            return fhtc_pkg::STS_FULL;
        if (mp && ms)
        begin
            tbl_size[p - 1] = ne - ns;
            table_remove(p);
        end
        else if (mp)
        begin
            tbl_size[p - 1] = ne - ns;
        end
        else if (ms)
        begin
            tbl_start[p] = ns;
            tbl_size[p] = ne - ns;
        end
        else
        begin
            for (i = tbl_count; i > p; i--)
            begin
                tbl_start[i] = tbl_start[i - 1];
                tbl_size[i] = tbl_size[i - 1];
            end
            tbl_start[p] = s;
            tbl_size[p] = l;
            tbl_count++;
        end
        return fhtc_pkg::STS_OK;
    endfunction

    // Apply one request to the table and work out its result item
    function automatic fhtc_pkg::rsp_item_t table_step(fhtc_pkg::req_item_t rq);
        fhtc_pkg::rsp_item_t rs;
        bit [63:0] a;
        bit [63:0] l;
        bit [63:0] rest;
        bit [63:0] save_start [MAX_HOLES];
        bit [63:0] save_size [MAX_HOLES];
        int save_count;
        int p;
        rs = '0;
        a = 64'(rq.address);
        l = 64'(rq.length);
        case (rq.command)
            fhtc_pkg::CMD_FREE:
            begin
                if (l != 0 && l - 1 > SPACE_TOP - a)
                    rs.status = fhtc_pkg::STS_FULL;
                else if (l != 0)
                    rs.status = table_insert(a, l);
            end
            fhtc_pkg::CMD_ALLOC:
            begin
                p = table_find(a);
                if (p < 0)
                    rs.status = fhtc_pkg::STS_NOT_FOUND;
                else if (tbl_size[p] < l)
                    rs.status = fhtc_pkg::STS_TOO_SMALL;
                else
                begin
                    save_start = tbl_start;
                    save_size = tbl_size;
                    save_count = tbl_count;
                    rest = tbl_size[p] - l;
                    table_remove(p);
                    if (rest != 0)
                        rs.status = table_insert(a + l, rest);
                    if (rs.status != fhtc_pkg::STS_OK)
                    begin
                        // put-back failed: undo the whole allocate
                        tbl_start = save_start;
                        tbl_size = save_size;
                        tbl_count = save_count;
                    end
                    else
                    begin
                        rs.result_address = 32'(a + l);
                    end
                end
            end
            fhtc_pkg::CMD_QUERY:
            begin
                p = table_find(a);
                if (p < 0)
                    rs.status = fhtc_pkg::STS_NOT_FOUND;
                else
                    rs.result_length = 32'(tbl_size[p]);
            end
            default:
            begin
                if (rq.rank >= tbl_count)
                    rs.status = fhtc_pkg::STS_RANGE;
                else
                begin
                    rs.result_address = 32'(tbl_start[rq.rank] - base_reg);
                    rs.result_length = 32'(tbl_size[rq.rank]);
                end
            end
        endcase
        rs.hole_total = TOTAL_W'(tbl_count);
        return rs;
    endfunction

    // Driver: present queued items in bursts, predict on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
                pending_rsp.push_back(table_step(req_item));
            if (!(req_valid && req_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() > 0)
                begin
                    req_item <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: long hold on request, otherwise stall in random segments
    always @(posedge clk)
    begin
        if (hold_seen != hold_trigger)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left <= $urandom_range(10, 80);
                seg_mode <= stall_mode_t'($urandom_range(0, 2));
            end
            else
            begin
                seg_left <= seg_left - 1;
            end
            case (seg_mode)
                STALL_NONE:  rsp_stall <= 1'b0;
                STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                default:     rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("result with none expected", 64'(rsp_item.result_address),
                                64'(0));
            end
            else
            begin
                want_rsp = pending_rsp.pop_front();
                if (rsp_item.status !== want_rsp.status)
                    report_mismatch("status", 64'(rsp_item.status), 64'(want_rsp.status));
                if (rsp_item.result_address !== want_rsp.result_address)
                    report_mismatch("result_address", 64'(rsp_item.result_address),
                                    64'(want_rsp.result_address));
                if (rsp_item.result_length !== want_rsp.result_length)
                    report_mismatch("result_length", 64'(rsp_item.result_length),
                                    64'(want_rsp.result_length));
                if (rsp_item.hole_total !== want_rsp.hole_total)
                    report_mismatch("hole_total", 64'(rsp_item.hole_total),
                                    64'(want_rsp.hole_total));
            end
        end
    end

    task automatic push_req(logic [CMD_W-1:0] cmd, logic [31:0] addr, logic [31:0] len,
                            logic [RANK_W-1:0] rank);
        fhtc_pkg::req_item_t rq;
        rq.command = cmd;
        rq.address = addr;
        rq.length = len;
        rq.rank = rank;
        while (req_backlog.size() >= 4)
            @(posedge clk);
        req_backlog.push_back(rq);
    endtask

    // Hold off until every queued item is taken and every result is back
    task automatic wait_idle();
        int n;
        n = 0;
        while ((req_backlog.size() != 0 || req_valid || pending_rsp.size() != 0)
               && n < WAIT_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_base(logic [31:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        base_reg = 64'(v);
        cfg_valid <= 1'b0;
    endtask

    // One random request, mostly on a small grid so holes touch and hit
    task automatic random_req(logic [31:0] win, logic [31:0] unit_sz);
        int r;
        int idx;
        logic [31:0] addr;
        logic [31:0] len;
        r = $urandom_range(0, 99);
        addr = win + $urandom_range(0, 47) * unit_sz;
        if (tbl_count > 0 && $urandom_range(0, 4) != 0)
        begin
            idx = $urandom_range(0, tbl_count - 1);
            if (r >= 40)
                addr = 32'(tbl_start[idx]);
        end
        else
        begin
            idx = -1;
        end
        if (r < 40)
        begin
            len = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom_range(1, 4) * unit_sz;
            push_req(fhtc_pkg::CMD_FREE, addr, len, RANK_W'($urandom));
        end
        else if (r < 65)
        begin
            case ($urandom_range(0, 3))
                0:       len = 0;
                1:       len = $urandom_range(1, 2) * unit_sz;
                2:       len = (idx >= 0) ? 32'(tbl_size[idx]) : unit_sz;
                default: len = $urandom_range(1, 6) * unit_sz;
            endcase
            push_req(fhtc_pkg::CMD_ALLOC, addr, len, RANK_W'($urandom));
        end
        else if (r < 77)
        begin
            push_req(fhtc_pkg::CMD_QUERY, addr, $urandom, RANK_W'($urandom));
        end
        else if (r < 90)
        begin
            push_req(fhtc_pkg::CMD_READ, $urandom, $urandom, RANK_W'($urandom));
        end
        else
        begin
            push_req(CMD_W'($urandom), $urandom, $urandom, RANK_W'($urandom));
        end
    endtask

    initial
    begin
        logic [31:0] win;
        logic [31:0] unit_sz;
        logic [31:0] base_val;
        int ph;
        int i;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_base(32'h0000_1000);

        // Directed: empty table, bounds, merges, allocate corner cases
        push_req(fhtc_pkg::CMD_READ,  32'h0,         32'h0,         4'd0);
        push_req(fhtc_pkg::CMD_QUERY, 32'h100,       32'h0,         4'd0);
        push_req(fhtc_pkg::CMD_ALLOC, 32'h100,       32'h4,         4'd0);
        push_req(fhtc_pkg::CMD_FREE,  32'h100,       32'h0,         4'd0);
        push_req(fhtc_pkg::CMD_FREE,  32'hFFFF_FFFF, 32'h2,         4'd0);
        push_req(fhtc_pkg::CMD_FREE,  32'hFFFF_FFFF, 32'h1,         4'd0);
        push_req(fhtc_pkg::CMD_FREE,  32'h100,       32'h40,        4'd0);
        push_req(fhtc_pkg::CMD_FREE,  32'h100,       32'h10,        4'd0);
        push_req(fhtc_pkg::CMD_FREE,  32'h180,       32'h40,        4'd0);
        push_req(fhtc_pkg::CMD_FREE,  32'h140,       32'h40,        4'd0);
        push_req(fhtc_pkg::CMD_ALLOC, 32'h100,       32'h100,       4'd0);
        push_req(fhtc_pkg::CMD_ALLOC, 32'h100,       32'h0,         4'd0);
        push_req(fhtc_pkg::CMD_ALLOC, 32'h100,       32'h40,        4'd0);
        push_req(fhtc_pkg::CMD_QUERY, 32'h140,       32'hFFFF_FFFF, 4'd0);
        push_req(fhtc_pkg::CMD_ALLOC, 32'h140,       32'h80,        4'd0);
        push_req(fhtc_pkg::CMD_READ,  32'h0,         32'h0,         4'd0);
        push_req(fhtc_pkg::CMD_FREE,  32'h0,         32'h8000_0000, 4'd0);
        push_req(fhtc_pkg::CMD_FREE,  32'h8000_0000, 32'h7FFF_FFFF, 4'd0);
        push_req(fhtc_pkg::CMD_FREE,  32'h8000_0000, 32'h7FFF_FFFE, 4'd0);
        push_req(fhtc_pkg::CMD_READ,  32'h0,         32'h0,         4'd1);
        push_req(fhtc_pkg::CMD_READ,  32'h0,         32'h0,         4'd15);
        push_req(fhtc_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'h1,         4'd0);
        push_req(fhtc_pkg::CMD_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
        push_req(fhtc_pkg::CMD_FREE,  32'h0,         32'hFFFF_FFFF, 4'd0);
        push_req(fhtc_pkg::CMD_ALLOC, 32'h0,         32'hFFFF_FFFE, 4'd0);
        wait_idle();

        // Random phases, each with its own base, with a new address window every 64 items
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       base_val = 32'hFFFF_FFFF;
                2:       base_val = 32'h0;
                3:       base_val = 32'h8000_0000;
                5:       base_val = 32'h1;
                default: base_val = $urandom;
            endcase
            write_base(base_val);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 64 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       unit_sz = 1;
                        1:       unit_sz = 16;
                        default: unit_sz = 4096;
                    endcase
                    case ($urandom_range(0, 3))
                        0:       win = 32'h0;
                        1:       win = 32'hFFFF_FFFF - $urandom_range(0, 50) * unit_sz;
                        default: win = $urandom;
                    endcase
                end
                // hold off the receiver while the sender keeps going
                if (ph == 1 && i == PHASE_ITEMS / 2)
                    hold_trigger++;
                // let everything drain before going on
                if (ph == 3 && i == PHASE_ITEMS / 2)
                    wait_idle();
                random_req(win, unit_sz);
            end
            wait_idle();
        end

        if (pending_rsp.size() != 0)
            report_mismatch("results never delivered", 64'(pending_rsp.size()), 64'(0));
        if (fail_count == 0)
            $display("free_hole_table_coalescing_top verification clean");
        else
            $display("free_hole_table_coalescing_top verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("free_hole_table_coalescing_top verification failed");
        $finish;
    end

endmodule
